// ===== design/crcpta_pkg.sv =====
package crcpta_pkg;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
  localparam logic [7:0]  TOP_FLIP  = 8'h80;
  localparam int          TRAIL_LEN = 4;
  localparam int          TRAIL_CW  = $clog2(TRAIL_LEN + 1);

  typedef struct packed {
    logic       update;
    logic       last;
    logic [7:0] data;
  } crc_ctl_t;

  // one byte of reflected CRC-32, bit at a time
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/crc32_packet_trailer_append.sv =====
// CRC-32 trailer appender.
// Input channel (in_valid/in_ready): one packet byte per item, in_last on the
// packet's final byte. Output channel (out_valid/out_ready): every data byte
// is passed through unchanged with out_is_crc low; after the last data byte
// four trailer bytes follow, least significant CRC byte first, each with
// bit 7 inverted, out_is_crc high, and out_last high on the fourth one.
// Each accepted byte is registered and appears on the output in the next cycle.
// Throughput: one byte per cycle while out_ready is high and no trailer is
// pending; the single output register emits the trailer bytes one per cycle
// and input is held off while trailer bytes remain.
// The byte-wide CRC update is combinational on the accepted byte, so a new
// byte is taken in each cycle the output slot frees with no trailer pending.
// Reset: output empty, no trailer pending, running CRC at all ones.
// Receiver stall: with out_ready low the output item holds, and in_ready
// drops until the slot is taken.
module crc32_packet_trailer_append (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_crc,
  output logic       out_last
);
  import crcpta_pkg::*;

  logic                slot_free;
  logic                accept;
  logic                trail_load;
  logic [TRAIL_CW-1:0] trail_cnt;
  logic [31:0]         trail_crc;
  logic [31:0]         fin;
  crc_ctl_t            ctl;

  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = slot_free && (trail_cnt == '0);
  assign accept     = in_valid && in_ready;
  assign trail_load = slot_free && (trail_cnt != '0);

  assign ctl.update = accept;
  assign ctl.last   = in_last;
  assign ctl.data   = in_byte;

  crcpta_crc u_crc (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .fin (fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      trail_cnt <= '0;
    end else if (accept) begin
      out_valid <= 1'b1;
      if (in_last) begin
        trail_cnt <= TRAIL_CW'(TRAIL_LEN);
      end
    end else if (trail_load) begin
      out_valid <= 1'b1;
      trail_cnt <= trail_cnt - 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte   <= in_byte;
      out_is_crc <= 1'b0;
      out_last   <= 1'b0;
      if (in_last) begin
        trail_crc <= fin;
      end
    end else if (trail_load) begin
      out_byte   <= trail_crc[7:0] ^ TOP_FLIP;
      out_is_crc <= 1'b1;
      out_last   <= (trail_cnt == TRAIL_CW'(1));
      trail_crc  <= trail_crc >> 8;
    end
  end

  a_last_starts_trailer: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> out_valid && !out_is_crc && trail_cnt == TRAIL_CW'(TRAIL_LEN))
    else $error("trailer not armed after last byte");

  a_trailer_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_is_crc && !out_last |-> trail_cnt != '0)
    else $error("trailer byte shown with no trailer pending");

  a_last_is_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_is_crc && trail_cnt == '0)
    else $error("packet end on a non-trailer byte");

endmodule

// ===== design/crcpta_crc.sv =====
module crcpta_crc (
  input  logic                clk,
  input  logic                rst,
  input  crcpta_pkg::crc_ctl_t ctl,
  output logic [31:0]         fin
);
  import crcpta_pkg::*;

  logic [31:0] crc;
  logic [31:0] crc_next;

  assign crc_next = crc_byte(crc, ctl.data);
  assign fin      = ~crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_ONES;
    end else if (ctl.update) begin
      crc <= ctl.last ? CRC_ONES : crc_next;
    end
  end

endmodule
